// ----- rtl/assert_macros.svh -----
// assertion macros used by the torus cell generator top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define TMCG_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("tmcg assertion failed");

// next-cycle implication
`define TMCG_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("tmcg assertion failed");

`endif

// ----- rtl/tmcg_pkg.sv -----
// types, codes and sine table builder for the torus cell generator
package tmcg_pkg;

  localparam int PHASE_W = 16;
  localparam int MIN_DIV = 3;

  localparam logic [1:0] KIND_VERTEX = 2'd0;
  localparam logic [1:0] KIND_CORNER = 2'd1;
  localparam logic [1:0] KIND_REJECT = 2'd2;

  localparam logic [1:0] REG_INNER = 2'd0;
  localparam logic [1:0] REG_OUTER = 2'd1;
  localparam logic [1:0] REG_RING  = 2'd2;
  localparam logic [1:0] REG_TUBE  = 2'd3;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] ONE_Q30     = 64'd1073741824;

  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_VTX  = 8'b0000_0010,
    ST_C0   = 8'b0000_0100,
    ST_C1   = 8'b0000_1000,
    ST_C2   = 8'b0001_0000,
    ST_C3   = 8'b0010_0000,
    ST_C4   = 8'b0100_0000,
    ST_C5   = 8'b1000_0000
  } step_e;

  typedef struct packed {
    logic       rej;
    logic [7:0] y;
    logic [7:0] x;
  } side_t;

  typedef struct packed {
    logic        rej;
    logic [15:0] idx0;
    logic [15:0] idx1;
    logic [15:0] idx2;
    logic [15:0] idx3;
    logic [15:0] u0;
    logic [15:0] u1;
    logic [15:0] v0;
    logic [15:0] v1;
  } corner_t;

  function automatic logic [15:0] sine_entry(input int unsigned idx, input int unsigned lg);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    x  = (64'(idx) * HALF_PI_Q30) >> lg;
    x2 = (x * x) >> 30;
    t  = ONE_Q30;
    t  = ONE_Q30 - (((x2 * t) >> 30) / 64'd110);
    t  = ONE_Q30 - (((x2 * t) >> 30) / 64'd72);
    t  = ONE_Q30 - (((x2 * t) >> 30) / 64'd42);
    t  = ONE_Q30 - (((x2 * t) >> 30) / 64'd20);
    t  = ONE_Q30 - (((x2 * t) >> 30) / 64'd6);
    s  = (x * t) >> 30;
    s  = (s + 64'd16384) >> 15;
    if (s > 64'd32767) begin
      s = 64'd32767;
    end
    return s[15:0];
  endfunction

  function automatic logic [23:0] sat24(input logic signed [31:0] v);
    logic [23:0] r;
    if (v > 32'sd8388607) begin
      r = 24'h7F_FFFF;
    end else if (v < -32'sd8388608) begin
      r = 24'h80_0000;
    end else begin
      r = v[23:0];
    end
    return r;
  endfunction

endpackage

// ----- rtl/tmcg_div.sv -----
// pipelined restoring divider, one quotient bit per stage
module tmcg_div #(
  parameter int DW = 9,
  parameter int QW = 16
) (
  input  logic          clk_i,
  input  logic [DW-1:0] den_i,
  input  logic [DW-1:0] hi_i,
  input  logic [QW-1:0] lo_i,
  output logic [QW-1:0] quo_o
);

  logic [DW-1:0] rem_q [QW];
  logic [DW-1:0] den_q [QW];
  logic [QW-1:0] lo_q  [QW];
  logic [QW-1:0] quo_q [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [DW-1:0] rem_in;
    logic [DW-1:0] den_in;
    logic [QW-1:0] lo_in;
    logic [QW-1:0] quo_in;
    logic [DW:0]   trial;
    logic          ge;
    logic [DW-1:0] rem_d;
    logic [QW-1:0] quo_d;

    if (k == 0) begin : g_first
      assign rem_in = hi_i;
      assign den_in = den_i;
      assign lo_in  = lo_i;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign den_in = den_q[k-1];
      assign lo_in  = lo_q[k-1];
      assign quo_in = quo_q[k-1];
    end

    always_comb begin
      trial = {rem_in, lo_in[QW-1-k]};
      ge    = (trial >= {1'b0, den_in});
      rem_d = ge ? DW'(trial - {1'b0, den_in}) : DW'(trial);
      quo_d = quo_in;
      quo_d[QW-1-k] = ge;
    end

    always_ff @(posedge clk_i) begin
      rem_q[k] <= rem_d;
      den_q[k] <= den_in;
      lo_q[k]  <= lo_in;
      quo_q[k] <= quo_d;
    end
  end

  assign quo_o = quo_q[QW-1];

endmodule

// ----- rtl/torus_mesh_cell_generator_unit.sv -----
// torus cell generator top level: config registers, arithmetic pipeline, result sequencer
// Each cell (ring_index_i, tube_index_i) taken on start yields seven results on consecutive
// cycles, the vertex then six triangle corners, or a single rejected result for a cell out
// of range. A start is taken only while busy is low; busy rises on each accepted start
// so that results of successive cells do not overlap on the single result port. Results
// pass a 16-stage divider for the phases and texture steps and six arithmetic stages.
// valid_o marks each result for one cycle and the receiver cannot stall it.
`include "assert_macros.svh"

module torus_mesh_cell_generator_unit #(
  parameter int MAX_DIVISIONS    = 256,
  parameter int SINE_TABLE_DEPTH = 256
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [7:0]         ring_index_i,
  input  logic [7:0]         tube_index_i,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output logic               valid_o,
  output logic [1:0]         kind_o,
  output logic signed [23:0] pos_x_o,
  output logic signed [23:0] pos_y_o,
  output logic signed [23:0] pos_z_o,
  output logic [15:0]        vertex_index_o,
  output logic [15:0]        map_u_o,
  output logic signed [15:0] map_v_o,
  output logic               last_o
);
  import tmcg_pkg::*;

  localparam int DW = $clog2(MAX_DIVISIONS + 1);
  localparam int LG = $clog2(SINE_TABLE_DEPTH);
  localparam int QW = PHASE_W;

  // configuration
  logic signed [23:0] inner_q, outer_q;
  logic [7:0]         ring_q, tube_q;
  logic               cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inner_q <= 24'sd0;
      outer_q <= 24'sd4096;
      ring_q  <= 8'd3;
      tube_q  <= 8'd3;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_INNER: inner_q <= pwdata[23:0];
        REG_OUTER: outer_q <= pwdata[23:0];
        REG_RING:  ring_q  <= pwdata[7:0];
        REG_TUBE:  tube_q  <= pwdata[7:0];
        default:   ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_INNER: prdata = 32'(inner_q);
      REG_OUTER: prdata = 32'(outer_q);
      REG_RING:  prdata = 32'(ring_q);
      REG_TUBE:  prdata = 32'(tube_q);
      default:   prdata = '0;
    endcase
  end

  logic [DW-1:0] eff_r, eff_t;

  always_comb begin
    if (ring_q < 8'(MIN_DIV)) begin
      eff_r = DW'(MIN_DIV);
    end else if (int'(ring_q) > MAX_DIVISIONS) begin
      eff_r = DW'(MAX_DIVISIONS);
    end else begin
      eff_r = DW'(ring_q);
    end
    if (tube_q < 8'(MIN_DIV)) begin
      eff_t = DW'(MIN_DIV);
    end else if (int'(tube_q) > MAX_DIVISIONS) begin
      eff_t = DW'(MAX_DIVISIONS);
    end else begin
      eff_t = DW'(tube_q);
    end
  end

  // input spacing
  logic [2:0] gap_q;
  logic       acc;

  assign busy = (gap_q != 3'd0);
  assign acc  = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gap_q <= 3'd0;
    end else if (acc) begin
      gap_q <= 3'd6;
    end else if (busy) begin
      gap_q <= gap_q - 3'd1;
    end
  end

  // divider stages
  logic [QW-1:0] pa, pb, du, dv;
  logic          vd_q   [QW];
  side_t         side_q [QW];

  tmcg_div #(.DW(DW), .QW(QW)) u_div_pa (
    .clk_i(clk_i), .den_i(eff_r), .hi_i(DW'(ring_index_i)), .lo_i('0), .quo_o(pa)
  );
  tmcg_div #(.DW(DW), .QW(QW)) u_div_pb (
    .clk_i(clk_i), .den_i(eff_t), .hi_i(DW'(tube_index_i)), .lo_i('0), .quo_o(pb)
  );
  tmcg_div #(.DW(DW), .QW(QW)) u_div_du (
    .clk_i(clk_i), .den_i(eff_r), .hi_i('0), .lo_i('1), .quo_o(du)
  );
  tmcg_div #(.DW(DW), .QW(QW)) u_div_dv (
    .clk_i(clk_i), .den_i(eff_t), .hi_i('0), .lo_i('1), .quo_o(dv)
  );

  for (genvar k = 0; k < QW; k++) begin : g_side
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vd_q[k] <= 1'b0;
      end else if (k == 0) begin
        vd_q[k] <= acc;
      end else begin
        vd_q[k] <= vd_q[(k == 0) ? 0 : k-1];
      end
    end
    always_ff @(posedge clk_i) begin
      if (k == 0) begin
        side_q[k] <= '{rej: (16'(ring_index_i) >= 16'(eff_r)) ||
                            (16'(tube_index_i) >= 16'(eff_t)),
                       y: ring_index_i, x: tube_index_i};
      end else begin
        side_q[k] <= side_q[(k == 0) ? 0 : k-1];
      end
    end
  end

  // sine table
  logic [15:0] sine_rom [SINE_TABLE_DEPTH];

  for (genvar gi = 0; gi < SINE_TABLE_DEPTH; gi++) begin : g_rom
    assign sine_rom[gi] = sine_entry(gi, LG);
  end

  // stage e1: trig lookup, sums, small products
  logic [QW-1:0]      ph [4];
  logic signed [16:0] trig_d [4];
  logic signed [16:0] trig_q [4];
  side_t              sd;
  logic [8:0]         xp, yp;
  logic [7:0]         x1_d, y1_d;

  assign sd    = side_q[QW-1];
  assign ph[0] = pa + 16'h4000;
  assign ph[1] = pa;
  assign ph[2] = pb + 16'h4000;
  assign ph[3] = pb;

  for (genvar l = 0; l < 4; l++) begin : g_trig
    logic [14:0] g;
    logic [LG:0] ix;
    logic [15:0] mag;
    always_comb begin
      g   = ph[l][14] ? (15'd16384 - {1'b0, ph[l][13:0]}) : {1'b0, ph[l][13:0]};
      ix  = (LG+1)'(g >> (14 - LG));
      mag = ix[LG] ? 16'd32767 : sine_rom[ix[LG-1:0]];
      trig_d[l] = ph[l][15] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    end
  end

  always_comb begin
    xp   = {1'b0, sd.x} + 9'd1;
    yp   = {1'b0, sd.y} + 9'd1;
    x1_d = (xp == 9'(eff_t)) ? 8'd0 : xp[7:0];
    y1_d = (yp == 9'(eff_r)) ? 8'd0 : yp[7:0];
  end

  logic               v1_q;
  logic               rej1_q;
  logic signed [24:0] sum1_q, dif1_q;
  logic [15:0]        u1_q, vx1_q, yt1_q, y1t1_q, du1_q, dv1_q;
  logic [7:0]         x1_q, xx1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= vd_q[QW-1];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int l = 0; l < 4; l++) begin
      trig_q[l] <= trig_d[l];
    end
    rej1_q <= sd.rej;
    sum1_q <= 25'(inner_q) + 25'(outer_q);
    dif1_q <= 25'(outer_q) - 25'(inner_q);
    u1_q   <= 16'(sd.y * du);
    vx1_q  <= 16'(sd.x * dv);
    yt1_q  <= 16'(sd.y) * 16'(eff_t);
    y1t1_q <= 16'(y1_d) * 16'(eff_t);
    du1_q  <= du;
    dv1_q  <= dv;
    x1_q   <= sd.x;
    xx1_q  <= x1_d;
  end

  // stage e2: radius products, corner fields
  logic               v2_q;
  logic signed [41:0] cbd2_q, sbd2_q;
  logic signed [16:0] ca2_q, sa2_q;
  logic signed [24:0] sum2_q;
  corner_t            cn2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    cbd2_q     <= trig_q[2] * dif1_q;
    sbd2_q     <= trig_q[3] * dif1_q;
    ca2_q      <= trig_q[0];
    sa2_q      <= trig_q[1];
    sum2_q     <= sum1_q;
    cn2_q.rej  <= rej1_q;
    cn2_q.idx0 <= yt1_q + 16'(x1_q);
    cn2_q.idx1 <= yt1_q + 16'(xx1_q);
    cn2_q.idx2 <= y1t1_q + 16'(x1_q);
    cn2_q.idx3 <= y1t1_q + 16'(xx1_q);
    cn2_q.u0   <= u1_q;
    cn2_q.u1   <= u1_q + du1_q;
    cn2_q.v0   <= vx1_q + 16'h8000;
    cn2_q.v1   <= vx1_q + dv1_q + 16'h8000;
  end

  // stage e3: w and pos_y
  logic signed [41:0] sx3, ty3, ry3;
  logic signed [41:0] w3_q;
  logic [23:0]        py3_q;
  logic signed [16:0] ca3_q, sa3_q;
  logic               v3_q;
  corner_t            cn3_q;

  always_comb begin
    sx3 = 42'(sum2_q);
    ty3 = sbd2_q + 42'sd32768;
    ry3 = ty3 >>> 16;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    w3_q  <= (sx3 <<< 15) + cbd2_q;
    py3_q <= sat24(32'(ry3));
    ca3_q <= ca2_q;
    sa3_q <= sa2_q;
    cn3_q <= cn2_q;
  end

  // stage e4: split products
  logic signed [21:0] wl4;
  logic signed [20:0] wh4;
  logic signed [38:0] pxl4_q, pzl4_q;
  logic signed [37:0] pxh4_q, pzh4_q;
  logic [23:0]        py4_q;
  logic               v4_q;
  corner_t            cn4_q;

  assign wl4 = $signed({1'b0, w3_q[20:0]});
  assign wh4 = w3_q[41:21];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    pxl4_q <= ca3_q * wl4;
    pxh4_q <= ca3_q * wh4;
    pzl4_q <= sa3_q * wl4;
    pzh4_q <= sa3_q * wh4;
    py4_q  <= py3_q;
    cn4_q  <= cn3_q;
  end

  // stage e5: recombine
  logic signed [59:0] hx5, lx5, hz5, lz5;
  logic signed [59:0] vx5_q, vz5_q;
  logic [23:0]        py5_q;
  logic               v5_q;
  corner_t            cn5_q;

  always_comb begin
    hx5 = 60'(pxh4_q);
    lx5 = 60'(pxl4_q);
    hz5 = 60'(pzh4_q);
    lz5 = 60'(pzl4_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
    end else begin
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    vx5_q <= (hx5 <<< 21) + lx5;
    vz5_q <= (hz5 <<< 21) + lz5;
    py5_q <= py4_q;
    cn5_q <= cn4_q;
  end

  // stage e6: round and saturate
  logic signed [59:0] tx6, tz6, rx6, rz6;
  logic [23:0]        px6_q, py6_q, pz6_q;
  logic               v6_q;
  corner_t            cn6_q;

  always_comb begin
    tx6 = vx5_q + (60'sd1 <<< 30);
    tz6 = vz5_q + (60'sd1 <<< 30);
    rx6 = tx6 >>> 31;
    rz6 = tz6 >>> 31;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v6_q <= 1'b0;
    end else begin
      v6_q <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    px6_q <= sat24(32'(rx6));
    pz6_q <= sat24(32'(rz6));
    py6_q <= py5_q;
    cn6_q <= cn5_q;
  end

  // result sequencer
  step_e       step_q, step_d;
  logic [23:0] px_q, py_q, pz_q;
  corner_t     hold_q;

  always_comb begin
    step_d = step_q;
    if (v6_q) begin
      step_d = ST_VTX;
    end else begin
      case (step_q)
        ST_IDLE: step_d = ST_IDLE;
        ST_VTX:  step_d = hold_q.rej ? ST_IDLE : ST_C0;
        ST_C0:   step_d = ST_C1;
        ST_C1:   step_d = ST_C2;
        ST_C2:   step_d = ST_C3;
        ST_C3:   step_d = ST_C4;
        ST_C4:   step_d = ST_C5;
        ST_C5:   step_d = ST_IDLE;
        default: step_d = ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= ST_IDLE;
    end else begin
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (v6_q) begin
      px_q   <= px6_q;
      py_q   <= py6_q;
      pz_q   <= pz6_q;
      hold_q <= cn6_q;
    end
  end

  assign valid_o = (step_q != ST_IDLE);

  always_comb begin
    kind_o         = KIND_CORNER;
    pos_x_o        = '0;
    pos_y_o        = '0;
    pos_z_o        = '0;
    vertex_index_o = hold_q.idx0;
    map_u_o        = hold_q.u0;
    map_v_o        = hold_q.v0;
    last_o         = 1'b0;
    case (step_q)
      ST_VTX: begin
        map_u_o = '0;
        map_v_o = '0;
        if (hold_q.rej) begin
          kind_o         = KIND_REJECT;
          vertex_index_o = '0;
          last_o         = 1'b1;
        end else begin
          kind_o  = KIND_VERTEX;
          pos_x_o = px_q;
          pos_y_o = py_q;
          pos_z_o = pz_q;
        end
      end
      ST_C0: ;
      ST_C1, ST_C4: begin
        vertex_index_o = hold_q.idx1;
        map_v_o        = hold_q.v1;
      end
      ST_C2, ST_C3: begin
        vertex_index_o = hold_q.idx2;
        map_u_o        = hold_q.u1;
      end
      ST_C5: begin
        vertex_index_o = hold_q.idx3;
        map_u_o        = hold_q.u1;
        map_v_o        = hold_q.v1;
        last_o         = 1'b1;
      end
      default: ;
    endcase
  end

  `TMCG_ASSERT_NXT(a_busy_after_start, start && !busy, busy)
  `TMCG_ASSERT_IMP(a_reject_is_last, valid_o && (kind_o == KIND_REJECT), last_o)
  `TMCG_ASSERT_IMP(a_no_overlap, v6_q, (step_q == ST_IDLE) || last_o)

endmodule
